FILE: design/wps_pkg.sv
// Shared types and constants for the WS2812 pixel serializer.
// No dependencies; imported by every module of the block.
package wps_pkg;

    localparam int TICK_W            = 10;
    localparam int BYTE_W            = 8;
    localparam int COLOR_BITS        = 24;
    localparam int DEF_BITS_PER_PIXEL = 24;
    localparam int IN_DATA_W         = 24;
    localparam int OUT_DATA_W        = 24;
    localparam int CFG_IDX_W         = 8;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QPTR_W            = 1;
    localparam int QCNT_W            = 2;

    localparam logic [TICK_W-1:0] RST_ZERO_HIGH = TICK_W'(20);
    localparam logic [TICK_W-1:0] RST_ZERO_LOW  = TICK_W'(42);
    localparam logic [TICK_W-1:0] RST_ONE_HIGH  = TICK_W'(40);
    localparam logic [TICK_W-1:0] RST_ONE_LOW   = TICK_W'(22);

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = CFG_IDX_W'(3);

    typedef struct packed {
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
    } timing_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0] word;   // green in the top byte, blue at the bottom
        logic                  last;
    } pixel_t;

endpackage

FILE: design/wps_front.sv
// Front end: accepts pixel transactions and queues them in wire order.
// Depends on wps_pkg.
module wps_front
    import wps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // green[7:0], red[15:8], blue[23:16]
    input  logic                 s_tlast,   // last pixel of the frame
    output logic                 q_valid,
    output pixel_t               q_pix,
    input  logic                 q_pop
);

    pixel_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push;
    pixel_t              in_pix;

    assign s_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_pix    = q_mem[rd_ptr_reg];

    always_comb begin
        in_pix.word = {s_tdata[BYTE_W-1:0], s_tdata[2*BYTE_W-1:BYTE_W],
                       s_tdata[3*BYTE_W-1:2*BYTE_W]};
        in_pix.last = s_tlast;
    end

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!push && q_pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_pix;
        end
    end

endmodule

FILE: design/wps_back.sv
// Back end: shifts a queued pixel out as one pulse description per bit.
// Depends on wps_pkg; fed by wps_front.
module wps_back
    import wps_pkg::*;
#(
    parameter int BITS_PER_PIXEL = DEF_BITS_PER_PIXEL
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  pixel_t                q_pix,
    output logic                  q_pop,
    input  timing_t               timing,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // line_bit[0], high_ticks[10:1], low_ticks[20:11]
    output logic                  m_tlast,  // last pulse of the pixel
    output logic                  m_tuser   // last pulse of the frame
);

    localparam int CNT_W = $clog2(BITS_PER_PIXEL);
    localparam int PAD_W = OUT_DATA_W - 2*TICK_W - 1;

    logic [BITS_PER_PIXEL-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      active_reg, active_next;
    logic                      frame_reg, frame_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_bit_reg, out_bit_next;
    logic [TICK_W-1:0]         out_high_reg, out_high_next;
    logic [TICK_W-1:0]         out_low_reg, out_low_next;
    logic                      out_lpix_reg, out_lpix_next;
    logic                      out_lfr_reg, out_lfr_next;
    logic                      advance, final_bit, cur_bit;

    assign cur_bit   = shift_reg[BITS_PER_PIXEL-1];
    assign final_bit = (cnt_reg == CNT_W'(BITS_PER_PIXEL - 1));
    assign advance   = active_reg && (!out_valid_reg || m_tready);
    assign q_pop     = q_valid && (!active_reg || (advance && final_bit));

    always_comb begin
        shift_next     = shift_reg;
        cnt_next       = cnt_reg;
        active_next    = active_reg;
        frame_next     = frame_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_bit_next   = out_bit_reg;
        out_high_next  = out_high_reg;
        out_low_next   = out_low_reg;
        out_lpix_next  = out_lpix_reg;
        out_lfr_next   = out_lfr_reg;
        if (advance) begin
            out_valid_next = 1'b1;
            out_bit_next   = cur_bit;
            out_high_next  = cur_bit ? timing.one_high : timing.zero_high;
            out_low_next   = cur_bit ? timing.one_low  : timing.zero_low;
            out_lpix_next  = final_bit;
            out_lfr_next   = final_bit && frame_reg;
            shift_next     = {shift_reg[BITS_PER_PIXEL-2:0], 1'b0};
            cnt_next       = cnt_reg + CNT_W'(1);
            if (final_bit) begin
                active_next = 1'b0;
            end
        end
        if (q_pop) begin
            shift_next  = BITS_PER_PIXEL'({q_pix.word,
                          {(BITS_PER_PIXEL-COLOR_BITS+1){1'b0}}} >> 1);
            cnt_next    = '0;
            active_next = 1'b1;
            frame_next  = q_pix.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg    <= shift_next;
        cnt_reg      <= cnt_next;
        frame_reg    <= frame_next;
        out_bit_reg  <= out_bit_next;
        out_high_reg <= out_high_next;
        out_low_reg  <= out_low_next;
        out_lpix_reg <= out_lpix_next;
        out_lfr_reg  <= out_lfr_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_low_reg, out_high_reg, out_bit_reg};
    assign m_tlast  = out_lpix_reg;
    assign m_tuser  = out_lfr_reg;

endmodule

FILE: design/ws2812_pixel_serializer_unit.sv
// WS2812 pixel serializer top level: timing registers, front queue, back serializer.
// Depends on wps_pkg, wps_front and wps_back.
//
// Each accepted pixel (green, red, blue, frame-end flag on tlast) becomes
// BITS_PER_PIXEL pulse transactions, green MSB first; bits past the 24 color
// bits encode zero. One pulse leaves per cycle while m_tready is high, shifted
// out of the single bit shifter in the back end; a two-entry queue lets the
// next pixels be taken while the current one drains, and pixels follow each
// other with no gap. m_tlast marks the last pulse of a pixel, m_tuser the
// last pulse of the frame. Pulse timings come from four registers that reset
// to datasheet values at 50 MHz and should be written only while no pixel is
// in flight.
module ws2812_pixel_serializer_unit
    import wps_pkg::*;
#(
    parameter int BITS_PER_PIXEL = DEF_BITS_PER_PIXEL
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // green[7:0], red[15:8], blue[23:16]
    input  logic                  s_tlast,   // last pixel of the frame
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // line_bit[0], high_ticks[10:1], low_ticks[20:11]
    output logic                  m_tlast,   // last pulse of the pixel
    output logic                  m_tuser,   // last pulse of the frame
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TICK_W-1:0]     cfg_wdata
);

    timing_t timing_reg, timing_next;
    logic    q_valid, q_pop;
    pixel_t  q_pix;

    always_comb begin
        timing_next = timing_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_ZERO_HIGH: timing_next.zero_high = cfg_wdata;
                CFG_ZERO_LOW:  timing_next.zero_low  = cfg_wdata;
                CFG_ONE_HIGH:  timing_next.one_high  = cfg_wdata;
                CFG_ONE_LOW:   timing_next.one_low   = cfg_wdata;
                default:       timing_next = timing_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.zero_high <= RST_ZERO_HIGH;
            timing_reg.zero_low  <= RST_ZERO_LOW;
            timing_reg.one_high  <= RST_ONE_HIGH;
            timing_reg.one_low   <= RST_ONE_LOW;
        end else begin
            timing_reg <= timing_next;
        end
    end

    wps_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_pix    (q_pix),
        .q_pop    (q_pop)
    );

    wps_back #(
        .BITS_PER_PIXEL (BITS_PER_PIXEL)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pix    (q_pix),
        .q_pop    (q_pop),
        .timing   (timing_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_frame_end_on_pixel_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end flagged on a pulse that does not end a pixel");

    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("pulse presented right after reset");

    a_pop_only_when_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("back end took a pixel from an empty queue");

endmodule

FILE: sim/wps_pulse_checker.sv
// Scoreboard for the WS2812 pixel serializer: tracks the timing registers,
// expands every accepted pixel into its pulses and checks the pulse stream.
// Depends on wps_pkg only; instantiated by tb_top next to the block.
module wps_pulse_checker
    import wps_pkg::*;
#(
    parameter int BITS_PER_PIXEL = DEF_BITS_PER_PIXEL
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tlast,
    input  logic                  m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TICK_W-1:0]     cfg_wdata,
    output int                    mismatch_count,
    output int                    pulses_pending,
    output int                    pulses_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              line_bit;
        logic [TICK_W-1:0] high_ticks;
        logic [TICK_W-1:0] low_ticks;
        logic              pixel_end;
        logic              frame_end;
    } pulse_t;

    timing_t pulse_timing;
    pulse_t  expected_pulses[$];

    function automatic void expand_pixel(input logic [BYTE_W-1:0] green,
                                         input logic [BYTE_W-1:0] red,
                                         input logic [BYTE_W-1:0] blue,
                                         input logic frame_last);
        logic [COLOR_BITS-1:0] word;
        pulse_t                p;
        int                    k;
        word = {green, red, blue};
        for (k = 0; k < BITS_PER_PIXEL; k++) begin
            if (k < COLOR_BITS) begin
                p.line_bit = word[COLOR_BITS-1-k];
            end else begin
                p.line_bit = 1'b0;
            end
            p.high_ticks = p.line_bit ? pulse_timing.one_high : pulse_timing.zero_high;
            p.low_ticks  = p.line_bit ? pulse_timing.one_low  : pulse_timing.zero_low;
            p.pixel_end  = (k == BITS_PER_PIXEL - 1);
            p.frame_end  = p.pixel_end && frame_last;
            expected_pulses.push_back(p);
        end
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t ns: pulse %0d %s mismatch, expected %0d actual %0d",
                     $time, pulses_checked, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        pulse_t want;
        if (!aresetn) begin
            pulse_timing   = '{RST_ZERO_HIGH, RST_ZERO_LOW, RST_ONE_HIGH, RST_ONE_LOW};
            expected_pulses.delete();
            mismatch_count = 0;
            pulses_checked = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ZERO_HIGH: pulse_timing.zero_high = cfg_wdata;
                    CFG_ZERO_LOW:  pulse_timing.zero_low  = cfg_wdata;
                    CFG_ONE_HIGH:  pulse_timing.one_high  = cfg_wdata;
                    CFG_ONE_LOW:   pulse_timing.one_low   = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expand_pixel(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (expected_pulses.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: unexpected pulse, expected none actual tdata=%h",
                             $time, m_tdata);
                end else begin
                    want = expected_pulses.pop_front();
                    check_field("line_bit",      int'(want.line_bit),   int'(m_tdata[0]));
                    check_field("high_ticks",    int'(want.high_ticks), int'(m_tdata[10:1]));
                    check_field("low_ticks",     int'(want.low_ticks),  int'(m_tdata[20:11]));
                    check_field("last_of_pixel", int'(want.pixel_end),  int'(m_tlast));
                    check_field("last_of_frame", int'(want.frame_end),  int'(m_tuser));
                end
                pulses_checked++;
            end
        end
        pulses_pending = expected_pulses.size();
    end

endmodule

FILE: sim/tb_top.sv
// Top-level testbench for ws2812_pixel_serializer_unit: clock, reset, pixel and
// register stimulus, randomized backpressure and the verdict.
// Depends on wps_pkg, the serializer RTL and wps_pulse_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wps_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(4);
    localparam logic [TICK_W-1:0]    TICK_MAX  = '1;
    localparam int                   RANDOM_PHASES  = 6;
    localparam int                   PHASE_PIXELS   = 60;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [TICK_W-1:0]     cfg_wdata;

    int mismatch_count;
    int pulses_pending;
    int pulses_checked;
    int pixels_sent;
    int timing_sets;
    bit tx_quiet;
    bit rx_quiet;
    bit hold_toggle;
    int hold_len;

    ws2812_pixel_serializer_unit dut (.*);

    wps_pulse_checker checker_i (.*);

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("timeout with %0d pulses outstanding", pulses_pending);
        $display("FAIL");
        $finish;
    end

    // sink side: random per-pulse stalls plus one long hold-off
    initial begin
        int  rx_wait;
        int  rx_hold;
        bit  seen_toggle;
        rx_wait     = 0;
        rx_hold     = 0;
        seen_toggle = 1'b0;
        m_tready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_toggle != seen_toggle) begin
                seen_toggle = hold_toggle;
                rx_hold     = hold_len;
            end
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else if (rx_wait > 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 19);
            end
        end
    end

    task automatic push_pixel(input logic [7:0] green, input logic [7:0] red,
                              input logic [7:0] blue, input logic frame_last);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, red, green};
        s_tlast  <= frame_last;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
    endtask

    task automatic push_random_pixel();
        push_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pulses_pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // spare-index write in every set must leave the timing untouched
    task automatic load_timing(input logic [TICK_W-1:0] zh, input logic [TICK_W-1:0] zl,
                               input logic [TICK_W-1:0] oh, input logic [TICK_W-1:0] ol);
        write_reg(CFG_ZERO_HIGH, zh);
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE, 255)), TICK_W'($urandom));
        write_reg(CFG_ZERO_LOW, zl);
        write_reg(CFG_ONE_HIGH, oh);
        write_reg(CFG_ONE_LOW, ol);
        @(negedge aclk);
        cfg_we <= 1'b0;
        timing_sets++;
    endtask

    function automatic logic [TICK_W-1:0] pick_ticks();
        case ($urandom_range(0, 7))
            0: return TICK_W'(1);
            1: return TICK_MAX;
            2: return TICK_W'(0);
            default: return TICK_W'($urandom_range(1, 1023));
        endcase
    endfunction

    initial begin
        int phase;
        int n;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        tx_quiet    = 1'b0;
        rx_quiet    = 1'b0;
        hold_toggle = 1'b0;
        hold_len    = 0;
        pixels_sent = 0;
        timing_sets = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // reset timing, extreme and walking colors
        push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        push_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
        push_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
        push_pixel(8'h80, 8'h01, 8'h80, 1'b1);
        push_pixel(8'h01, 8'h80, 8'h01, 1'b0);
        push_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
        push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        push_pixel(8'h00, 8'h00, 8'hFF, 1'b1);
        wait_drained();

        load_timing(TICK_W'(1), TICK_W'(1), TICK_W'(1), TICK_W'(1));
        push_pixel(8'hA5, 8'h5A, 8'hC3, 1'b1);
        push_pixel(8'h3C, 8'hF0, 8'h0F, 1'b0);
        wait_drained();
        load_timing(TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX);
        push_pixel(8'h96, 8'h69, 8'hE1, 1'b0);
        push_pixel(8'h1E, 8'h87, 8'h78, 1'b1);
        wait_drained();
        // zero-valued timing registers pass straight through
        load_timing(TICK_W'(0), TICK_W'(0), TICK_W'(0), TICK_W'(0));
        push_pixel(8'hF0, 8'h0F, 8'hAA, 1'b1);
        push_pixel(8'h0F, 8'hF0, 8'h55, 1'b0);
        wait_drained();
        load_timing(TICK_MAX, TICK_W'(1), TICK_W'(1), TICK_MAX);
        push_pixel(8'hCC, 8'h33, 8'h99, 1'b1);
        push_pixel(8'h33, 8'hCC, 8'h66, 1'b0);
        wait_drained();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_timing(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
            for (n = 0; n < PHASE_PIXELS; n++) begin
                if (n % 20 == 0) begin
                    tx_quiet = ($urandom_range(0, 3) == 0);
                    rx_quiet = ($urandom_range(0, 3) == 0);
                end
                if (phase == 1 && n == 10) begin
                    // stall the sink long enough to back the queue up into s_tready
                    hold_len    = 400;
                    hold_toggle = ~hold_toggle;
                    tx_quiet    = 1'b1;
                end
                push_random_pixel();
            end
            wait_drained();
        end

        repeat (24) @(negedge aclk);
        $display("sent %0d pixels under %0d timing sets, %0d pulses checked",
                 pixels_sent, timing_sets, pulses_checked);
        $display("covered extreme and zero timings, spare register writes, long sink stall");
        if (mismatch_count == 0 && pulses_pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: ws2812_pixel_serializer_unit.f
design/wps_pkg.sv
design/wps_front.sv
design/wps_back.sv
design/ws2812_pixel_serializer_unit.sv
sim/wps_pulse_checker.sv
sim/tb_top.sv
